>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/kchc_pkg.sv
`timescale 1ns / 1ps

package kchc_pkg;

    localparam int KCHC_NUM_KEYS = 8;
    localparam int KCHC_MAX_KEYS = 8;

    localparam int LEVELS_W    = 8;
    localparam int KEY_IDX_W   = 3;
    localparam int KIND_W      = 2;
    localparam int COUNT_W     = 8;
    localparam int TIME_W      = 16;
    localparam int PERIOD_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIME_W-1:0]   TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST  = 8'd10;
    localparam logic [TIME_W-1:0]   PRESS_THR_RST    = 16'd30;
    localparam logic [TIME_W-1:0]   HOLD_THR_RST     = 16'd1000;
    localparam logic [TIME_W-1:0]   INTERVAL_THR_RST = 16'd300;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_PERIOD  = 2'd0,
        REG_PRESS_THR    = 2'd1,
        REG_HOLD_THR     = 2'd2,
        REG_INTERVAL_THR = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_RELEASE  = 3'd0,
        MODE_DEBOUNCE = 3'd1,
        MODE_PENDING  = 3'd2,
        MODE_BETWEEN  = 3'd3,
        MODE_PRESS    = 3'd4,
        MODE_HOLD     = 3'd5,
        MODE_MULTI    = 3'd6
    } key_mode_t;

    typedef enum logic [KIND_W-1:0] {
        EV_PRESS = 2'd0,
        EV_HOLD  = 2'd1,
        EV_MULTI = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_FLUSH
    } seq_state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] scan_period;
        logic [TIME_W-1:0]   press_thr;
        logic [TIME_W-1:0]   hold_thr;
        logic [TIME_W-1:0]   interval_thr;
    } kchc_cfg_t;

    typedef struct packed {
        key_mode_t          mode;
        logic [TIME_W-1:0]  held;
        logic [TIME_W-1:0]  gap;
        logic [COUNT_W-1:0] count;
    } key_state_t;

endpackage

>>> rtl/kchc_key_unit.sv
`timescale 1ns / 1ps

module kchc_key_unit
    import kchc_pkg::*;
(
    input  kchc_cfg_t   cfg,
    input  logic        pressed,
    input  key_state_t  cur,
    output key_state_t  nxt,
    output logic        ev_valid,
    output event_kind_t ev_kind
);

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [PERIOD_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] a);
        return (a == COUNT_MAX) ? COUNT_MAX : a + COUNT_W'(1);
    endfunction

    always_comb
    begin
        logic [TIME_W-1:0] held_base;
        logic [TIME_W-1:0] held_n;
        logic [TIME_W-1:0] gap_n;

        // Held time is kept on release only while debouncing or holding.
        held_base = (!pressed && cur.mode != MODE_DEBOUNCE && cur.mode != MODE_HOLD)
                    ? '0 : cur.held;
        held_n = pressed ? sat_add(held_base, cfg.scan_period) : held_base;
        gap_n  = (cur.mode == MODE_PENDING || cur.mode == MODE_BETWEEN)
                 ? sat_add(cur.gap, cfg.scan_period) : '0;

        nxt.mode  = cur.mode;
        nxt.held  = held_n;
        nxt.gap   = gap_n;
        nxt.count = cur.count;
        ev_valid  = 1'b0;
        ev_kind   = EV_PRESS;

        unique case (cur.mode)
            MODE_RELEASE:
            begin
                nxt.count = '0;
                if (pressed)
                begin
                    nxt.mode = MODE_DEBOUNCE;
                end
            end
            MODE_DEBOUNCE:
            begin
                if (held_n > cfg.hold_thr)
                begin
                    nxt.mode = MODE_HOLD;
                end
                if (!pressed)
                begin
                    if (held_n > cfg.press_thr && held_n < cfg.hold_thr)
                    begin
                        nxt.mode  = MODE_PENDING;
                        nxt.count = sat_inc(cur.count);
                    end
                    else
                    begin
                        nxt.mode = MODE_RELEASE;
                    end
                end
            end
            MODE_PENDING, MODE_BETWEEN:
            begin
                if (gap_n < cfg.interval_thr)
                begin
                    if (held_n > cfg.press_thr)
                    begin
                        nxt.mode  = MODE_MULTI;
                        nxt.count = sat_inc(cur.count);
                    end
                end
                else if (cur.mode == MODE_PENDING)
                begin
                    nxt.mode = MODE_PRESS;
                end
                else
                begin
                    ev_valid = 1'b1;
                    ev_kind  = EV_MULTI;
                    nxt.mode = MODE_RELEASE;
                end
            end
            MODE_PRESS:
            begin
                ev_valid = 1'b1;
                ev_kind  = EV_PRESS;
                if (!pressed)
                begin
                    nxt.mode = MODE_RELEASE;
                end
            end
            MODE_HOLD:
            begin
                if (!pressed)
                begin
                    ev_valid = 1'b1;
                    ev_kind  = EV_HOLD;
                    nxt.mode = MODE_RELEASE;
                end
            end
            MODE_MULTI:
            begin
                if (!pressed)
                begin
                    nxt.mode = MODE_BETWEEN;
                end
            end
            default:
            begin
                // The unused mode code is sticky and reports nothing.
            end
        endcase
    end

endmodule

>>> rtl/key_click_hold_classifier_unit.sv
`timescale 1ns / 1ps

// Key click and hold classifier.
// Each input request is one scan tick: key_levels holds the raw level of each
// key, and a 0 bit means the key is pressed. The block walks the keys one per
// cycle, except while the scan waits on a stalled output, through a single
// shared classifier unit. It scans min(NUM_KEYS, 8) keys, then flushes any
// held-back last event, and only after that accepts a new tick. in_stall
// stays high for the whole scan and the flush.
// Each key gives at most one event per tick, in ascending key order. The
// latest event is held back one slot so that last_of_tick can be set on the
// final event of the tick; a tick with no events gives no output request.
// Results leave through an output register, which holds still while the
// receiver holds out_stall. If an event is already held back and the output
// is stalled, the scan waits at the next key that has an event.
// Configuration writes via cfg_we / cfg_index / cfg_data take effect at once
// and are meant to be made while the block is idle.
// Reset returns every key to the release state with cleared timers and
// counts, and loads the default scan period and thresholds.

module key_click_hold_classifier_unit
    import kchc_pkg::*;
#(
    parameter int NUM_KEYS = KCHC_NUM_KEYS
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LEVELS_W-1:0]   key_levels,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_IDX_W-1:0]  key_index,
    output logic [KIND_W-1:0]     event_kind,
    output logic [COUNT_W-1:0]    click_total,
    output logic                  last_of_tick
);

    localparam int KEYS   = (NUM_KEYS > KCHC_MAX_KEYS) ? KCHC_MAX_KEYS : NUM_KEYS;
    localparam int KIDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam logic [KIDX_W-1:0] LAST_KEY = KIDX_W'(KEYS - 1);

    kchc_cfg_t   cfg_reg;
    key_state_t  keys_reg [KEYS];

    seq_state_t  state_reg, state_next;
    logic [KIDX_W-1:0]   key_cnt_reg;
    logic [LEVELS_W-1:0] levels_reg;

    logic                pend_valid_reg;
    logic [KEY_IDX_W-1:0] pend_key_reg;
    event_kind_t         pend_kind_reg;
    logic [COUNT_W-1:0]  pend_count_reg;

    logic                out_valid_reg;
    logic [KEY_IDX_W-1:0] out_key_reg;
    event_kind_t         out_kind_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_last_reg;

    key_state_t  cur_key;
    key_state_t  nxt_key;
    logic        ev_valid;
    event_kind_t ev_kind;

    logic        out_free;
    logic        accept;
    logic        key_update;
    logic        pend_load;
    logic        pend_clear;
    logic        out_load;
    logic        out_last;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_period  <= SCAN_PERIOD_RST;
            cfg_reg.press_thr    <= PRESS_THR_RST;
            cfg_reg.hold_thr     <= HOLD_THR_RST;
            cfg_reg.interval_thr <= INTERVAL_THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SCAN_PERIOD:  cfg_reg.scan_period  <= cfg_data[PERIOD_W-1:0];
                REG_PRESS_THR:    cfg_reg.press_thr    <= cfg_data[TIME_W-1:0];
                REG_HOLD_THR:     cfg_reg.hold_thr     <= cfg_data[TIME_W-1:0];
                REG_INTERVAL_THR: cfg_reg.interval_thr <= cfg_data[TIME_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cur_key = keys_reg[key_cnt_reg];

    kchc_key_unit u_key_unit (
        .cfg      (cfg_reg),
        .pressed  (!levels_reg[key_cnt_reg]),
        .cur      (cur_key),
        .nxt      (nxt_key),
        .ev_valid (ev_valid),
        .ev_kind  (ev_kind)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        key_update = 1'b0;
        pend_load  = 1'b0;
        pend_clear = 1'b0;
        out_load   = 1'b0;
        out_last   = 1'b0;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    accept     = 1'b1;
                    state_next = SEQ_SCAN;
                end
            end
            SEQ_SCAN:
            begin
                // A new event pushes the held-back one out, so it needs room.
                if (!(ev_valid && pend_valid_reg && !out_free))
                begin
                    key_update = 1'b1;
                    pend_load  = ev_valid;
                    out_load   = ev_valid && pend_valid_reg;
                    if (key_cnt_reg == LAST_KEY)
                    begin
                        state_next = SEQ_FLUSH;
                    end
                end
            end
            SEQ_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = SEQ_IDLE;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    pend_clear = 1'b1;
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Per-key classifier state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                keys_reg[k] <= '{mode: MODE_RELEASE, held: '0, gap: '0, count: '0};
            end
        end
        else if (key_update)
        begin
            keys_reg[key_cnt_reg] <= nxt_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                key_cnt_reg <= '0;
            end
            else if (key_update && key_cnt_reg != LAST_KEY)
            begin
                key_cnt_reg <= key_cnt_reg + KIDX_W'(1);
            end

            if (pend_load)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_clear)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            levels_reg <= key_levels;
        end
        if (out_load)
        begin
            out_key_reg   <= pend_key_reg;
            out_kind_reg  <= pend_kind_reg;
            out_count_reg <= pend_count_reg;
            out_last_reg  <= out_last;
        end
        if (pend_load)
        begin
            pend_key_reg   <= KEY_IDX_W'(key_cnt_reg);
            pend_kind_reg  <= ev_kind;
            pend_count_reg <= nxt_key.count;
        end
    end

    assign in_stall     = (state_reg != SEQ_IDLE);
    assign out_valid    = out_valid_reg;
    assign key_index    = out_key_reg;
    assign event_kind   = out_kind_reg;
    assign click_total  = out_count_reg;
    assign last_of_tick = out_last_reg;

endmodule

>>> rtl/kchc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kchc_checker
    import kchc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [KEY_IDX_W-1:0] key_index,
    input logic [KIND_W-1:0]    event_kind,
    input logic [COUNT_W-1:0]   click_total,
    input logic                 last_of_tick
);

    // A stalled result holds still.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(key_index) && $stable(event_kind) && $stable(click_total) && $stable(last_of_tick))

    // Once a tick is accepted the block is busy scanning.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // An event that is not the last of its tick means the scan is still running.
    `ASSERT_IMPLIES(a_more_events_busy, clk, rst_n, out_valid && !last_of_tick, in_stall)

    // Only the three defined event kinds appear.
    `ASSERT_IMPLIES(a_kind_legal, clk, rst_n, out_valid, event_kind <= KIND_W'(EV_MULTI))

endmodule

bind key_click_hold_classifier_unit kchc_checker u_kchc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .key_index    (key_index),
    .event_kind   (event_kind),
    .click_total  (click_total),
    .last_of_tick (last_of_tick)
);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import kchc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int IDLE_PCT    = 37;
    localparam int SETTLE      = 20;
    localparam int PLAN_LEN    = 22;

    // Pressed ticks per key for the directed sequences, tick 0 at the left.
    localparam logic [PLAN_LEN-1:0] PRESSED_PLAN [8] = '{
        22'b1111_0000_0000_0000_0000_00,   // single click, one press event
        22'b1111_0000_0001_1100_0000_00,   // single click, pressed again in press
        22'b1111_0111_1000_0000_0000_00,   // double click
        22'b1111_1111_1010_0000_0000_00,   // long hold, then a blip after it
        22'b1100_0111_0000_0000_0000_00,   // taps too short to count
        22'b1111_1111_0000_0000_0000_00,   // held exactly to the hold threshold
        22'b1111_1111_1111_1111_1111_10,   // long hold released at the end
        22'b1111_0111_1011_1100_0000_00    // triple click
    };

    typedef struct {
        logic [KEY_IDX_W-1:0] key;
        event_kind_t          kind;
        logic [COUNT_W-1:0]   clicks;
        logic                 last;
    } key_event_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [LEVELS_W-1:0] key_levels;
    logic out_valid;
    logic out_stall;
    logic [KEY_IDX_W-1:0] key_index;
    logic [KIND_W-1:0] event_kind;
    logic [COUNT_W-1:0] click_total;
    logic last_of_tick;

    // Predictor state and register shadows.
    key_mode_t          mode_q   [8];
    logic [TIME_W-1:0]  held_q   [8];
    logic [TIME_W-1:0]  gap_q    [8];
    logic [COUNT_W-1:0] clicks_q [8];
    logic [PERIOD_W-1:0] scan_period_r;
    logic [TIME_W-1:0]   press_thr_r;
    logic [TIME_W-1:0]   hold_thr_r;
    logic [TIME_W-1:0]   interval_thr_r;

    key_event_t pending_events[$];
    int fail_count = 0;
    int ticks_sent = 0;
    int events_seen = 0;
    int settings_used = 0;
    int cycles = 0;
    bit steady = 1'b0;

    always #2 clk = ~clk;

    key_click_hold_classifier_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key_levels   (key_levels),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_index    (key_index),
        .event_kind   (event_kind),
        .click_total  (click_total),
        .last_of_tick (last_of_tick)
    );

    function automatic logic [TIME_W-1:0] add_sat16(logic [TIME_W-1:0] a,
                                                    logic [PERIOD_W-1:0] b);
        logic [TIME_W:0] sum;
        sum = a + b;
        return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] bump_clicks(logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
    endfunction

    // Advances every key's classifier by one scan tick and queues its events.
    task automatic classify_tick(input logic [LEVELS_W-1:0] lv);
        logic pressed;
        key_mode_t m;
        logic fire;
        event_kind_t kind;
        key_event_t ev;
        int first_new;
        first_new = pending_events.size();
        for (int k = 0; k < 8; k++)
        begin
            pressed = !lv[k];
            m = mode_q[k];
            fire = 1'b0;
            kind = EV_PRESS;
            if (!pressed && m != MODE_DEBOUNCE && m != MODE_HOLD)
                held_q[k] = '0;
            if (pressed)
                held_q[k] = add_sat16(held_q[k], scan_period_r);
            if (m == MODE_PENDING || m == MODE_BETWEEN)
                gap_q[k] = add_sat16(gap_q[k], scan_period_r);
            else
                gap_q[k] = '0;
            case (m)
                MODE_RELEASE:
                begin
                    clicks_q[k] = '0;
                    if (pressed)
                        mode_q[k] = MODE_DEBOUNCE;
                end
                MODE_DEBOUNCE:
                begin
                    if (held_q[k] > hold_thr_r)
                        mode_q[k] = MODE_HOLD;
                    if (!pressed)
                    begin
                        if (held_q[k] > press_thr_r && held_q[k] < hold_thr_r)
                        begin
                            mode_q[k] = MODE_PENDING;
                            clicks_q[k] = bump_clicks(clicks_q[k]);
                        end
                        else
                            mode_q[k] = MODE_RELEASE;
                    end
                end
                MODE_PENDING, MODE_BETWEEN:
                begin
                    if (gap_q[k] < interval_thr_r)
                    begin
                        if (held_q[k] > press_thr_r)
                        begin
                            mode_q[k] = MODE_MULTI;
                            clicks_q[k] = bump_clicks(clicks_q[k]);
                        end
                    end
                    else if (m == MODE_PENDING)
                        mode_q[k] = MODE_PRESS;
                    else
                    begin
                        fire = 1'b1;
                        kind = EV_MULTI;
                        mode_q[k] = MODE_RELEASE;
                    end
                end
                MODE_PRESS:
                begin
                    fire = 1'b1;
                    kind = EV_PRESS;
                    if (!pressed)
                        mode_q[k] = MODE_RELEASE;
                end
                MODE_HOLD:
                begin
                    if (!pressed)
                    begin
                        fire = 1'b1;
                        kind = EV_HOLD;
                        mode_q[k] = MODE_RELEASE;
                    end
                end
                MODE_MULTI:
                begin
                    if (!pressed)
                        mode_q[k] = MODE_BETWEEN;
                end
                default:
                    ;
            endcase
            if (fire)
            begin
                ev.key = k[KEY_IDX_W-1:0];
                ev.kind = kind;
                ev.clicks = clicks_q[k];
                ev.last = 1'b0;
                pending_events.push_back(ev);
            end
        end
        if (pending_events.size() > first_new)
            pending_events[pending_events.size()-1].last = 1'b1;
    endtask

    // Offers one scan tick, with random idle cycles ahead of it unless steady is set.
    task automatic send_tick(input logic [LEVELS_W-1:0] lv);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key_levels <= lv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        classify_tick(lv);
        ticks_sent++;
    endtask

    // Ticks that produce no event still occupy the scan, hence the settle time.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCAN_PERIOD:  scan_period_r = val[PERIOD_W-1:0];
            REG_PRESS_THR:    press_thr_r = val;
            REG_HOLD_THR:     hold_thr_r = val;
            REG_INTERVAL_THR: interval_thr_r = val;
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // The upper byte of the scan period write is junk that the block must drop.
    task automatic set_timing(input int sp, input int press, input int hold,
                              input int interval);
        logic [7:0] junk;
        junk = $urandom_range(0, 255);
        wait_idle();
        write_reg(REG_SCAN_PERIOD, {junk, sp[7:0]});
        write_reg(REG_PRESS_THR, press[15:0]);
        write_reg(REG_HOLD_THR, hold[15:0]);
        write_reg(REG_INTERVAL_THR, interval[15:0]);
        settings_used++;
    endtask

    // Each key alternates between pressed and released runs of random length,
    // so that most keys walk through whole click sequences.
    task automatic run_key_scripts(input int n_ticks, input int down_cap,
                                   input int up_cap, input int noise_pct);
        logic [LEVELS_W-1:0] lv;
        logic [LEVELS_W-1:0] word;
        int left [8];
        lv = '1;
        for (int k = 0; k < 8; k++)
            left[k] = $urandom_range(0, 3);
        for (int t = 0; t < n_ticks; t++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (left[k] == 0)
                begin
                    lv[k] = ~lv[k];
                    left[k] = lv[k] ? $urandom_range(1, up_cap)
                                    : $urandom_range(1, down_cap);
                end
                else
                    left[k]--;
            end
            word = lv;
            if ($urandom_range(0, 99) < noise_pct)
                word[$urandom_range(0, 7)] ^= 1'b1;
            send_tick(word);
        end
    endtask

    task automatic run_phase(input int sp, input int press, input int hold,
                             input int interval, input int n_ticks,
                             input int noise_pct, input bit calm);
        int step;
        int down_cap;
        int up_cap;
        set_timing(sp, press, hold, interval);
        step = (sp == 0) ? 1 : sp;
        down_cap = hold / step + 3;
        up_cap = interval / step + 3;
        if (down_cap > 110)
            down_cap = 110;
        if (up_cap > 40)
            up_cap = 40;
        steady = calm;
        run_key_scripts(n_ticks, down_cap, up_cap, noise_pct);
        steady = 1'b0;
    endtask

    task automatic test_directed_sequences();
        logic [LEVELS_W-1:0] word;
        set_timing(10, 30, 80, 60);
        for (int t = 0; t < PLAN_LEN; t++)
        begin
            for (int k = 0; k < 8; k++)
                word[k] = ~PRESSED_PLAN[k][PLAN_LEN-1-t];
            send_tick(word);
        end
    endtask

    // With a zero scan period no timer moves, so a key whose held time starts at zero stalls in debounce.
    task automatic test_zero_scan_period();
        set_timing(0, 30, 80, 60);
        send_tick(8'h00);
        send_tick(8'h00);
        send_tick(8'hAA);
        send_tick(8'hFF);
        send_tick(8'h55);
    endtask

    task automatic test_random_settings();
        run_phase(10, 30, 120, 60, 20, 5, 1'b1);
        run_phase(1, 0, 5, 3, 8, 10, 1'b0);
        run_phase(255, 65535, 65535, 0, 6, 10, 1'b0);
    endtask

    // Key 0 holds long enough to pin the held time, key 1 waits long enough
    // after one click to pin the gap time.
    task automatic test_timer_saturation();
        logic [5:0] upper;
        set_timing(255, 0, 65534, 65535);
        for (int t = 0; t < 266; t++)
        begin
            upper = $urandom_range(0, 63);
            send_tick({upper, (t == 0) ? 1'b0 : 1'b1, (t < 260) ? 1'b0 : 1'b1});
        end
    endtask

    always @(posedge clk)
    begin : check_events
        key_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event: key %0d kind %0d clicks %0d",
                       key_index, event_kind, click_total);
                fail_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                events_seen++;
                if (key_index !== want.key)
                begin
                    $error("key_index: expected %0d, got %0d", want.key, key_index);
                    fail_count++;
                end
                if (event_kind !== want.kind)
                begin
                    $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
                    fail_count++;
                end
                if (click_total !== want.clicks)
                begin
                    $error("click_total: expected %0d, got %0d", want.clicks, click_total);
                    fail_count++;
                end
                if (last_of_tick !== want.last)
                begin
                    $error("last_of_tick: expected %0d, got %0d", want.last, last_of_tick);
                    fail_count++;
                end
            end
        end
        out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $error("timeout with %0d events outstanding", pending_events.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_SCAN_PERIOD;
        cfg_data <= '0;
        in_valid <= 1'b0;
        key_levels <= '1;
        out_stall <= 1'b0;
        scan_period_r = SCAN_PERIOD_RST;
        press_thr_r = PRESS_THR_RST;
        hold_thr_r = HOLD_THR_RST;
        interval_thr_r = INTERVAL_THR_RST;
        for (int k = 0; k < 8; k++)
        begin
            mode_q[k] = MODE_RELEASE;
            held_q[k] = '0;
            gap_q[k] = '0;
            clicks_q[k] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sequences();
        test_zero_scan_period();
        test_random_settings();
        test_timer_saturation();
        wait_idle();

        if (pending_events.size() != 0)
        begin
            $error("%0d expected events never arrived", pending_events.size());
            fail_count++;
        end
        $display("Run covered %0d scan ticks and %0d checked key events", ticks_sent,
                 events_seen);
        $display("over %0d timing settings, including zero and saturated timers.",
                 settings_used);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> key_click_hold_classifier_unit.f
+incdir+rtl
rtl/kchc_pkg.sv
rtl/kchc_key_unit.sv
rtl/key_click_hold_classifier_unit.sv
rtl/kchc_checker.sv
verif/tb.sv
